FILE: rtl/mes_pkg.sv
package mes_pkg;

  // field and datapath widths
  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;
  localparam int COLOR_BITS  = 8;
  localparam int OFF_BITS    = RADIUS_BITS + 2;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int DEC_BITS    = 4 * RADIUS_BITS;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;
  localparam int MUL_A_BITS  = SQ_BITS + 1;
  localparam int MUL_B_BITS  = OFF_BITS + 3;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int SUM_BITS    = ((COORD_BITS + 2 > OFF_BITS) ? COORD_BITS + 2 : OFF_BITS) + 1;

  typedef logic        [COORD_BITS-1:0]  coord_t;
  typedef logic        [RADIUS_BITS-1:0] radius_t;
  typedef logic        [COLOR_BITS-1:0]  color_t;
  typedef logic signed [OFF_BITS-1:0]    off_t;
  typedef logic signed [OUT_BITS-1:0]    out_t;
  typedef logic signed [DEC_BITS-1:0]    dec_t;
  typedef logic        [SQ_BITS-1:0]     sq_t;
  typedef logic signed [MUL_A_BITS-1:0]  mul_a_t;
  typedef logic signed [MUL_B_BITS-1:0]  mul_b_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // request opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_t;

  // drawing phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  // multiplier operand selection; u is the coordinate that always steps,
  // v the one that steps on a non-negative decision, k and l the squared radii that scale u and v
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,
    MUL_YY,
    MUL_A2_INIT,
    MUL_L_ONE_MINUS_V,
    MUL_K_FOUR_U,
    MUL_K_U_NEXT,
    MUL_L_V_NEXT,
    MUL_B2_SETUP
  } mul_sel_t;

  // datapath action on the registered product
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD_A2,
    ACT_LOAD_B2,
    ACT_INIT_D,
    ACT_D_STEP,
    ACT_D_ADD,
    ACT_HOLD_C,
    ACT_FINISH,
    ACT_SETUP2,
    ACT_EMPTY
  } act_t;

  // sequencing
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_DONE,
    SEQ_BRANCH
  } seq_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_START  = 4'd0;
  localparam pc_t PC_ITER   = 4'd4;
  localparam pc_t PC_SETUP2 = 4'd9;
  localparam pc_t PC_EMPTY  = 4'd11;

  typedef struct packed {
    mul_sel_t mul;
    act_t     act;
    seq_t     seq;
    pc_t      target;
  } ctrl_t;

  // requests from the datapath to the sequencer
  typedef struct packed {
    logic launch;
    pc_t  entry;
    logic stall;
    logic take;
  } seq_cmd_t;

  localparam ctrl_t CTRL_IDLE = '{MUL_NONE, ACT_NONE, SEQ_DONE, PC_START};

  // control store
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    case (pc)
      // start: squares of both radii, then the first-half decision
      4'd0:    w = '{MUL_AA,            ACT_NONE,    SEQ_NEXT,   PC_START};
      4'd1:    w = '{MUL_YY,            ACT_LOAD_A2, SEQ_NEXT,   PC_START};
      4'd2:    w = '{MUL_A2_INIT,       ACT_LOAD_B2, SEQ_NEXT,   PC_START};
      4'd3:    w = '{MUL_NONE,          ACT_INIT_D,  SEQ_NEXT,   PC_START};
      // one iteration: four products through the shared multiplier
      4'd4:    w = '{MUL_L_ONE_MINUS_V, ACT_NONE,    SEQ_NEXT,   PC_START};
      4'd5:    w = '{MUL_K_FOUR_U,      ACT_D_STEP,  SEQ_NEXT,   PC_START};
      4'd6:    w = '{MUL_K_U_NEXT,      ACT_D_ADD,   SEQ_NEXT,   PC_START};
      4'd7:    w = '{MUL_L_V_NEXT,      ACT_HOLD_C,  SEQ_NEXT,   PC_START};
      4'd8:    w = '{MUL_NONE,          ACT_FINISH,  SEQ_BRANCH, PC_SETUP2};
      // second-half setup
      4'd9:    w = '{MUL_B2_SETUP,      ACT_NONE,    SEQ_NEXT,   PC_START};
      4'd10:   w = '{MUL_NONE,          ACT_SETUP2,  SEQ_DONE,   PC_START};
      // next with nothing drawing
      4'd11:   w = '{MUL_NONE,          ACT_EMPTY,   SEQ_DONE,   PC_START};
      default: w = CTRL_IDLE;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/mes_if.sv
// request channel
interface mes_req_if;
  import mes_pkg::*;

  logic    valid;
  logic    ready;
  op_t     op;
  coord_t  center_x;
  coord_t  center_y;
  radius_t radius_x;
  radius_t radius_y;
  color_t  color;

  modport source (output valid, op, center_x, center_y, radius_x, radius_y, color,
                  input ready);
  modport sink   (input valid, op, center_x, center_y, radius_x, radius_y, color,
                  output ready);
endinterface

// result channel
interface mes_res_if;
  import mes_pkg::*;

  logic   valid;
  logic   ready;
  logic   valid_res;
  out_t   x_right;
  out_t   x_left;
  out_t   y_below;
  out_t   y_above;
  color_t pixel_color;
  logic   last;

  modport source (output valid, valid_res, x_right, x_left, y_below, y_above, pixel_color,
                  last, input ready);
  modport sink   (input valid, valid_res, x_right, x_left, y_below, y_above, pixel_color,
                  last, output ready);
endinterface

FILE: rtl/midpoint_ellipse_stepper.sv
// Midpoint ellipse stepper: each request emits one iteration of the midpoint
// ellipse algorithm as one result with the four mirrored points and the colour.
// A start request latches centre, radii and colour and emits the first point;
// next requests emit the following points, the first half (x stepping) and then
// the second half (y stepping), with last set on the final one. A next request
// while nothing is drawing gives one result with valid_res low. One request is
// worked on at a time, so req.ready stays low from the taking of a request
// until its result is loaded into the output register, and for the step that
// closes the first half until the second half is set up as well; a finished
// result waits in the output register while the following request is taken.
// The pace is set by the single shared multiplier, which forms four products
// per iteration under a microcoded step counter.
module midpoint_ellipse_stepper (
  input  logic           clk,
  input  logic           rst,
  mes_req_if.sink        req,
  mes_res_if.source      res
);
  import mes_pkg::*;

  seq_cmd_t cmd;
  ctrl_t    ctrl;
  logic     busy;

  // drawing state
  phase_t  phase;
  off_t    x;
  off_t    y;
  dec_t    d;
  sq_t     a2;
  sq_t     b2;
  radius_t a_lat;
  coord_t  col;
  coord_t  row;
  color_t  clr;
  logic    step_v;
  prod_t   prod;
  prod_t   c_hold;

  // output register
  logic   out_valid;
  logic   out_valid_res;
  out_t   out_x_right;
  out_t   out_x_left;
  out_t   out_y_below;
  out_t   out_y_above;
  color_t out_color;
  logic   out_last;

  // operand muxes
  logic   accept;
  logic   first_half;
  off_t   u;
  off_t   v;
  off_t   u_next;
  off_t   v_next;
  sq_t    k;
  sq_t    l;
  mul_a_t ma;
  mul_b_t mb;
  logic   mul_en;
  logic   emit;
  logic   out_free;
  logic   stall;
  logic   load;
  logic   fail;
  logic   last_now;

  mes_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .busy (busy),
    .ctrl (ctrl)
  );

  // request handshake and sequencer entry
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;

  always_comb begin
    cmd.launch = accept;
    if (req.op == OP_START) begin
      cmd.entry = PC_START;
    end else if (phase == PH_FIRST || phase == PH_SECOND) begin
      cmd.entry = PC_ITER;
    end else begin
      cmd.entry = PC_EMPTY;
    end
    cmd.stall = stall;
    cmd.take  = first_half && fail;
  end

  // role swap between the halves
  always_comb begin
    first_half = (phase == PH_FIRST);
    u      = first_half ? x : y;
    v      = first_half ? y : x;
    k      = first_half ? b2 : a2;
    l      = first_half ? a2 : b2;
    u_next = u + off_t'(1);
    v_next = step_v ? v - off_t'(1) : v;
  end

  // shared multiplier operands
  always_comb begin
    case (ctrl.mul)
      MUL_AA: begin
        ma = mul_a_t'({1'b0, a_lat});
        mb = mul_b_t'({1'b0, a_lat});
      end
      MUL_YY: begin
        ma = mul_a_t'(y);
        mb = mul_b_t'(y);
      end
      MUL_A2_INIT: begin
        ma = {1'b0, a2};
        mb = mul_b_t'(1) - (mul_b_t'(y) <<< 1);
      end
      MUL_L_ONE_MINUS_V: begin
        ma = {1'b0, l};
        mb = mul_b_t'(1) - mul_b_t'(v);
      end
      MUL_K_FOUR_U: begin
        ma = {1'b0, k};
        mb = (mul_b_t'(u) <<< 2) + mul_b_t'(6);
      end
      MUL_K_U_NEXT: begin
        ma = {1'b0, k};
        mb = mul_b_t'(u_next);
      end
      MUL_L_V_NEXT: begin
        ma = {1'b0, l};
        mb = mul_b_t'(v_next);
      end
      MUL_B2_SETUP: begin
        ma = {1'b0, b2};
        mb = mul_b_t'(1) - (mul_b_t'({1'b0, a_lat}) <<< 1);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // emit control and loop test
  always_comb begin
    mul_en   = (ctrl.mul != MUL_NONE);
    emit     = (ctrl.act == ACT_FINISH) || (ctrl.act == ACT_EMPTY);
    out_free = !out_valid || res.ready;
    stall    = emit && !out_free;
    load     = emit && out_free;
    fail     = (c_hold > prod);
    last_now = (phase == PH_SECOND) && fail;
  end

  // product register
  always_ff @(posedge clk) begin
    if (mul_en && !stall) begin
      prod <= ma * mb;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && req.op == OP_START) begin
      col   <= req.center_x;
      row   <= req.center_y;
      clr   <= req.color;
      a_lat <= req.radius_x;
      x     <= '0;
      y     <= off_t'(req.radius_y);
    end
    if (!stall) begin
      case (ctrl.act)
        ACT_LOAD_A2: a2 <= sq_t'(prod);
        ACT_LOAD_B2: b2 <= sq_t'(prod);
        ACT_INIT_D:  d  <= dec_t'({b2, 1'b0}) + dec_t'(prod);
        ACT_D_STEP: begin
          step_v <= !d[DEC_BITS-1];
          if (!d[DEC_BITS-1]) begin
            d <= d + (dec_t'(prod) <<< 2);
          end
        end
        ACT_D_ADD:  d      <= d + dec_t'(prod);
        ACT_HOLD_C: c_hold <= prod;
        ACT_FINISH: begin
          if (first_half) begin
            x <= u_next;
            y <= v_next;
          end else begin
            y <= u_next;
            x <= v_next;
          end
        end
        ACT_SETUP2: begin
          d <= dec_t'({a2, 1'b0}) + dec_t'(prod);
          x <= off_t'({1'b0, a_lat});
          y <= '0;
        end
        default: ;
      endcase
    end
  end

  // phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept && req.op == OP_START) begin
      phase <= PH_FIRST;
    end else if (!stall) begin
      case (ctrl.act)
        ACT_FINISH: begin
          if (last_now) begin
            phase <= PH_IDLE;
          end
        end
        ACT_SETUP2: phase <= PH_SECOND;
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (ctrl.act == ACT_FINISH) begin
        out_valid_res <= 1'b1;
        out_x_right   <= out_t'(sum_t'({1'b0, col}) + sum_t'(x));
        out_x_left    <= out_t'(sum_t'({1'b0, col}) - sum_t'(x));
        out_y_below   <= out_t'(sum_t'({1'b0, row}) + sum_t'(y));
        out_y_above   <= out_t'(sum_t'({1'b0, row}) - sum_t'(y));
        out_color     <= clr;
        out_last      <= last_now;
      end else begin
        out_valid_res <= 1'b0;
        out_x_right   <= '0;
        out_x_left    <= '0;
        out_y_below   <= '0;
        out_y_above   <= '0;
        out_color     <= '0;
        out_last      <= 1'b0;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.valid_res   = out_valid_res;
  assign res.x_right     = out_x_right;
  assign res.x_left      = out_x_left;
  assign res.y_below     = out_y_below;
  assign res.y_above     = out_y_above;
  assign res.pixel_color = out_color;
  assign res.last        = out_last;

  // a start request always begins the first half under sequencer control
  a_start_first: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_START) |=> (phase == PH_FIRST && busy))
    else $error("start request did not begin the first half");

  // the final point of the second half leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && ctrl.act == ACT_FINISH && last_now) |=> (phase == PH_IDLE && !busy))
    else $error("last point did not return to idle");

  // second-half setup starts on the horizontal axis
  a_setup_axis: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_SETUP2) |=> (phase == PH_SECOND && y == '0 && !busy))
    else $error("second-half setup left wrong state");

endmodule

FILE: rtl/mes_seq.sv
module mes_seq (
  input  logic             clk,
  input  logic             rst,
  input  mes_pkg::seq_cmd_t cmd,
  output logic             busy,
  output mes_pkg::ctrl_t   ctrl
);
  import mes_pkg::*;

  pc_t   pc;
  ctrl_t word;

  // control word fetch
  always_comb begin
    word = ucode(pc);
    ctrl = busy ? word : CTRL_IDLE;
  end

  // step counter with conditional jump
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_START;
    end else if (!busy) begin
      if (cmd.launch) begin
        busy <= 1'b1;
        pc   <= cmd.entry;
      end
    end else if (!cmd.stall) begin
      case (word.seq)
        SEQ_NEXT: pc <= pc + pc_t'(1);
        SEQ_BRANCH: begin
          if (cmd.take) begin
            pc <= word.target;
          end else begin
            busy <= 1'b0;
          end
        end
        SEQ_DONE: busy <= 1'b0;
        default:  busy <= 1'b0;
      endcase
    end
  end

endmodule

FILE: tb/midpoint_ellipse_stepper_tb.sv
module midpoint_ellipse_stepper_tb;
  import mes_pkg::*;

  localparam int ITEM_TOTAL  = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam int WALK_CAP    = 300;

  // one result: the four mirrored points and the colour
  typedef struct packed {
    logic   valid_res;
    out_t   x_right;
    out_t   x_left;
    out_t   y_below;
    out_t   y_above;
    color_t pixel_color;
    logic   last;
  } point_set_t;

  // one row of the directed part
  typedef struct packed {
    op_t        op;
    coord_t     cx;
    coord_t     cy;
    radius_t    rx;
    radius_t    ry;
    color_t     col;
    logic       typed;
    point_set_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  mes_req_if req_ch ();
  mes_res_if res_ch ();

  midpoint_ellipse_stepper dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  point_set_t expected_points[$];
  stim_row_t  stim_table[$];
  int         err_count  = 0;
  int         sent_count = 0;
  int         cycle_count = 0;
  int         src_idle_pct  = 0;
  int         sink_stall_pct = 0;

  // shadow of the rasterizer state
  phase_t draw_phase = PH_IDLE;
  longint off_x   = 0;
  longint off_y   = 0;
  longint dec     = 0;
  longint a_sq    = 0;
  longint b_sq    = 0;
  longint a_hold  = 0;
  longint ctr_col = 0;
  longint ctr_row = 0;
  color_t col_hold = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // two's-complement wrap into a register of the given width
  function automatic longint wrap_to(input longint v, input int bits);
    longint lim;
    longint u;
    lim = longint'(1) << bits;
    u = v & (lim - 1);
    if (u >= (lim >>> 1)) u = u - lim;
    return u;
  endfunction

  // advance the shadow rasterizer by one request
  function automatic point_set_t step_ellipse(input op_t op, input coord_t cx, input coord_t cy,
                                              input radius_t rx, input radius_t ry,
                                              input color_t col);
    point_set_t p;
    longint x;
    longint y;
    longint d;
    longint b;
    p = '0;
    if (op == OP_START) begin
      b = longint'(ry);
      ctr_col  = longint'(cx);
      ctr_row  = longint'(cy);
      col_hold = col;
      a_hold   = longint'(rx);
      a_sq     = a_hold * a_hold;
      b_sq     = b * b;
      off_x    = 0;
      off_y    = b;
      dec      = wrap_to(2 * b_sq + a_sq * (1 - 2 * b), DEC_BITS);
      draw_phase = PH_FIRST;
    end
    // nothing drawing: empty result
    if (draw_phase != PH_FIRST && draw_phase != PH_SECOND) begin
      draw_phase = PH_IDLE;
      return p;
    end
    x = off_x;
    y = off_y;
    d = dec;
    p.valid_res   = 1'b1;
    p.x_right     = out_t'(ctr_col + x);
    p.x_left      = out_t'(ctr_col - x);
    p.y_below     = out_t'(ctr_row + y);
    p.y_above     = out_t'(ctr_row - y);
    p.pixel_color = col_hold;
    if (draw_phase == PH_FIRST) begin
      // first half: x steps, y steps on a non-negative decision
      if (d >= 0) begin
        d = d + 4 * a_sq * (1 - y);
        y = y - 1;
      end
      d = d + b_sq * (4 * x + 6);
      x = wrap_to(x + 1, OFF_BITS);
      y = wrap_to(y, OFF_BITS);
      d = wrap_to(d, DEC_BITS);
      if (!(b_sq * x <= a_sq * y)) begin
        x = a_hold;
        y = 0;
        d = wrap_to(2 * a_sq + b_sq * (1 - 2 * a_hold), DEC_BITS);
        draw_phase = PH_SECOND;
      end
    end else begin
      // second half: y steps, x steps on a non-negative decision
      if (d >= 0) begin
        d = d + 4 * b_sq * (1 - x);
        x = x - 1;
      end
      d = d + a_sq * (4 * y + 6);
      y = y + 1;
      x = wrap_to(x, OFF_BITS);
      y = wrap_to(y, OFF_BITS);
      d = wrap_to(d, DEC_BITS);
      if (!(a_sq * y <= b_sq * x)) begin
        p.last = 1'b1;
        draw_phase = PH_IDLE;
      end
    end
    off_x = x;
    off_y = y;
    dec   = d;
    return p;
  endfunction

  // directed rows, checked against the predictor
  function automatic void add_row(input op_t op, input int cx, input int cy, input int rx,
                                  input int ry, input int col);
    stim_row_t r;
    r = '0;
    r.op  = op;
    r.cx  = coord_t'(cx);
    r.cy  = coord_t'(cy);
    r.rx  = radius_t'(rx);
    r.ry  = radius_t'(ry);
    r.col = color_t'(col);
    stim_table.push_back(r);
  endfunction

  // directed rows with the result typed in
  function automatic void add_known(input op_t op, input int cx, input int cy, input int rx,
                                    input int ry, input int col, input int vr, input int xr,
                                    input int xl, input int yb, input int ya, input int pc,
                                    input int lst);
    point_set_t w;
    add_row(op, cx, cy, rx, ry, col);
    w.valid_res   = vr[0];
    w.x_right     = out_t'(xr);
    w.x_left      = out_t'(xl);
    w.y_below     = out_t'(yb);
    w.y_above     = out_t'(ya);
    w.pixel_color = color_t'(pc);
    w.last        = lst[0];
    stim_table[$].typed = 1'b1;
    stim_table[$].want  = w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < 50) $display("mismatch %s: got %0d, want %0d", what, got, want);
    err_count++;
  endtask

  // drive one request and wait for it to be taken
  task automatic send_req(input op_t op, input coord_t cx, input coord_t cy, input radius_t rx,
                          input radius_t ry, input color_t col, input logic typed,
                          input point_set_t want, output logic fin);
    point_set_t p;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    p = step_ellipse(op, cx, cy, rx, ry, col);
    expected_points.push_back(typed ? want : p);
    fin = p.last;
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.center_x <= cx;
    req_ch.center_y <= cy;
    req_ch.radius_x <= rx;
    req_ch.radius_y <= ry;
    req_ch.color    <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // next request with junk in the unused fields
  task automatic send_next(output logic fin);
    send_req(OP_NEXT, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom),
             radius_t'($urandom), color_t'($urandom), 1'b0, '0, fin);
  endtask

  task automatic send_start(input int rmax, output logic fin);
    send_req(OP_START, coord_t'($urandom), coord_t'($urandom),
             radius_t'($urandom_range(0, rmax)), radius_t'($urandom_range(0, rmax)),
             color_t'($urandom), 1'b0, '0, fin);
  endtask

  // result side: check then choose the next ready
  initial begin
    point_set_t w;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result, valid_res", longint'(res_ch.valid_res), 0);
        end else begin
          w = expected_points.pop_front();
          if (res_ch.valid_res !== w.valid_res)
            report_mismatch("valid_res", longint'(res_ch.valid_res), longint'(w.valid_res));
          if (res_ch.x_right !== w.x_right)
            report_mismatch("x_right", longint'(res_ch.x_right), longint'(w.x_right));
          if (res_ch.x_left !== w.x_left)
            report_mismatch("x_left", longint'(res_ch.x_left), longint'(w.x_left));
          if (res_ch.y_below !== w.y_below)
            report_mismatch("y_below", longint'(res_ch.y_below), longint'(w.y_below));
          if (res_ch.y_above !== w.y_above)
            report_mismatch("y_above", longint'(res_ch.y_above), longint'(w.y_above));
          if (res_ch.pixel_color !== w.pixel_color)
            report_mismatch("pixel_color", longint'(res_ch.pixel_color),
                            longint'(w.pixel_color));
          if (res_ch.last !== w.last)
            report_mismatch("last", longint'(res_ch.last), longint'(w.last));
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // stimulus
  initial begin
    logic fin;
    int   rand_base;
    int   span;
    int   kind;
    int   steps;
    int   k;

    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= OP_NEXT;
    req_ch.center_x <= '0;
    req_ch.center_y <= '0;
    req_ch.radius_x <= '0;
    req_ch.radius_y <= '0;
    req_ch.color    <= '0;

    // next after reset, extremes, zero radii, a restart mid-draw
    add_known(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_known(OP_START, 1023, 1023, 511, 511, 255, 1, 1023, 1023, 1534, 512, 255, 0);
    add_row(OP_NEXT, 0, 0, 0, 0, 0);
    add_known(OP_START, 0, 0, 511, 511, 0, 1, 0, 0, 511, -511, 0, 0);
    add_row(OP_NEXT, 0, 0, 0, 0, 0);
    add_known(OP_START, 5, 7, 0, 0, 8'hA5, 1, 5, 5, 7, 7, 8'hA5, 0);
    for (k = 0; k < 3; k++) add_row(OP_NEXT, 0, 0, 0, 0, 0);
    add_known(OP_START, 100, 200, 3, 0, 8'h5A, 1, 100, 100, 200, 200, 8'h5A, 0);
    for (k = 0; k < 5; k++) add_row(OP_NEXT, 0, 0, 0, 0, 0);
    add_known(OP_START, 512, 512, 0, 3, 1, 1, 512, 512, 515, 509, 1, 0);
    for (k = 0; k < 4; k++) add_row(OP_NEXT, 0, 0, 0, 0, 0);
    add_known(OP_START, 300, 400, 1, 1, 8'h80, 1, 300, 300, 401, 399, 8'h80, 0);
    for (k = 0; k < 3; k++) add_row(OP_NEXT, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_req(stim_table[i].op, stim_table[i].cx, stim_table[i].cy, stim_table[i].rx,
               stim_table[i].ry, stim_table[i].col, stim_table[i].typed, stim_table[i].want,
               fin);
    end

    // random part in four idling phases
    rand_base = sent_count;
    span = (ITEM_TOTAL - rand_base) / 4;
    while (sent_count < ITEM_TOTAL) begin
      case ((sent_count - rand_base) / span)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 63; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 63; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        // whole ellipse, mostly small
        k = $urandom_range(0, 99);
        send_start((k < 85) ? 15 : ((k < 97) ? 63 : 511), fin);
        steps = 0;
        while (!fin && steps < WALK_CAP) begin
          send_next(fin);
          steps++;
        end
        if (fin && $urandom_range(0, 9) == 0) send_next(fin);
      end else if (kind < 92) begin
        // ellipse dropped part way by a new start
        send_start(511, fin);
        steps = $urandom_range(0, 20);
        for (k = 0; k < steps; k++) send_next(fin);
      end else begin
        // stray next requests
        steps = $urandom_range(1, 3);
        for (k = 0; k < steps; k++) send_next(fin);
      end
    end
    req_ch.valid <= 1'b0;

    // drain
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0 && expected_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mes_pkg.sv
rtl/mes_if.sv
rtl/mes_seq.sv
rtl/midpoint_ellipse_stepper.sv
tb/midpoint_ellipse_stepper_tb.sv
